// ----- rtl/tmcw_pkg.sv -----
// ============================================================================
// tmcw_pkg: shared types and constants for the text mode console writer
// Field widths, command and register codes, control characters, the
// controller state type and the command/status structs between controller
// and datapath.
// ============================================================================
`default_nettype none

package tmcw_pkg;

  // Default screen geometry.
  localparam int DEF_COLUMNS   = 80;
  localparam int DEF_ROWS      = 25;
  localparam int DEF_TAB_WIDTH = 8;

  // Field widths of the stream payloads.
  localparam int CMD_FW  = 2;
  localparam int CHAR_FW = 8;
  localparam int ADDR_FW = 11;
  localparam int COL_FW  = 7;
  localparam int ROW_FW  = 5;
  localparam int LOC_FW  = 11;
  localparam int DATA_FW = 16;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  // Bit positions inside in_tdata.
  localparam int CMD_LSB  = 0;
  localparam int CHAR_LSB = CMD_LSB + CMD_FW;
  localparam int ADDR_LSB = CHAR_LSB + CHAR_FW;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int COLOR_W    = 4;

  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 1'b1;

  localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;
  localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;

  // Command codes.
  localparam logic [CMD_FW-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_FW-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_FW-1:0] CMD_READ  = 2'd2;

  // Character codes with special meaning.
  localparam logic [CHAR_FW-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_FW-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_FW-1:0] CH_LINE_FEED = 8'h0A;
  localparam logic [CHAR_FW-1:0] CH_CR        = 8'h0D;
  localparam logic [CHAR_FW-1:0] CH_SPACE     = 8'h20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUT,
    ST_SCROLL,
    ST_FILL,
    ST_READ,
    ST_RESP
  } tmcw_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_item;   // capture the accepted input item
    logic home_cursor;  // cursor to row 0, column 0
    logic ptr_clear;    // sweep pointer back to cell 0
    logic do_put;       // execute a put-character on the latched byte
    logic copy_step;    // one step of the scroll copy
    logic fill_step;    // write one blank cell at the sweep pointer
    logic read_cell;    // read the latched cell address
    logic load_out;     // load the result register
  } tmcw_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scroll_req;   // the put in progress moves past the last row
    logic copy_done;    // the scroll copy reached the last row
    logic fill_done;    // the fill reached the last cell
  } tmcw_stat_t;

endpackage

`default_nettype wire

// ----- rtl/text_mode_console_writer.sv -----
// ============================================================================
// text_mode_console_writer: character terminal engine over a text screen
// Accepts put, clear and read commands and returns the cursor position for
// each one and the cell read for a read.
// ============================================================================
// The block keeps a COLUMNS x ROWS screen of 16-bit cells (attribute in the
// high byte, character in the low byte) in one single-port-write memory and
// a cursor. Every input transfer produces exactly one output transfer that
// reports the cursor after the command. A put of a printable byte or of a
// control byte passes through the put step, and a read through the read
// step, before the result is loaded; an unused command goes straight to
// the result. A new transfer can be taken in the same cycle as the result
// of the last one is loaded. A put that moves past the last row scrolls: it
// copies every row one row up and then blanks the last row. A clear writes
// every cell once and then loads the result. The screen memory takes one
// write per cycle. The result register lets the next command be accepted
// and executed while a finished result still waits for out_tready. The
// screen is not cleared by reset: issue a clear before the first read.
// The user must write the color registers through the cfg port only while
// the block is idle; the block itself does not enforce this. They apply to
// all following cells.
// ============================================================================
`default_nettype none

module text_mode_console_writer #(
  parameter int COLUMNS   = tmcw_pkg::DEF_COLUMNS,
  parameter int ROWS      = tmcw_pkg::DEF_ROWS,
  parameter int TAB_WIDTH = tmcw_pkg::DEF_TAB_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input stream.
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // in_tdata: command[1:0], char_code[9:2], cell_address[20:10], zero [23:21]
  input  wire logic [tmcw_pkg::IN_TDATA_W-1:0]   in_tdata,
  // Result stream.
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // out_tdata: cursor_column[6:0], cursor_row[11:7], cursor_location[22:12],
  //            read_data[38:23], zero [39]
  output logic      [tmcw_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // Configuration: index 0 background color, index 1 foreground color.
  input  wire logic                              cfg_we,
  input  wire logic [tmcw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tmcw_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import tmcw_pkg::*;

  tmcw_ctrl_t ctl;
  tmcw_stat_t sts;

  // The controller decodes the command of the item on offer so that it can
  // pick the first step in the same cycle as the transfer.
  tmcw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_command (in_tdata[CMD_LSB +: CMD_FW]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl),
    .sts        (sts)
  );

  // The datapath holds the screen, the cursor and the result register.
  tmcw_dp #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .sts       (sts)
  );

  // A new item is never taken while the screen memory is being swept.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !(ctl.copy_step || ctl.fill_step))
    else $error("input transfer during a memory sweep");

  // The result register is loaded only when it is empty or being drained.
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_out |-> (!out_tvalid || out_tready))
    else $error("result overwritten before its transfer");

  // The scroll copy hands over to the blanking of the last row.
  assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.copy_step && sts.copy_done) |=> ctl.fill_step)
    else $error("scroll copy not followed by last row fill");

  // Reset leaves no result pending.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

// ----- rtl/tmcw_ctrl.sv -----
// ============================================================================
// tmcw_ctrl: sequencing controller of the text mode console writer
// Walks each item through put, scroll, fill and read steps and owns the
// input ready and the result valid flag.
// ============================================================================
`default_nettype none

module tmcw_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [tmcw_pkg::CMD_FW-1:0]   in_command,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output tmcw_pkg::tmcw_ctrl_t               ctl,
  input  wire tmcw_pkg::tmcw_stat_t          sts
);
  import tmcw_pkg::*;

  tmcw_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;
  logic        accept;

  function automatic tmcw_state_t dispatch(input logic [CMD_FW-1:0] cmd);
    tmcw_state_t st;
    case (cmd)
      CMD_PUT:   st = ST_PUT;
      CMD_CLEAR: st = ST_FILL;
      CMD_READ:  st = ST_READ;
      default:   st = ST_RESP;
    endcase
    return st;
  endfunction

  assign slot_free  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = dispatch(in_command);
      end
      ST_PUT: begin
        state_nxt = sts.scroll_req ? ST_SCROLL : ST_RESP;
      end
      ST_SCROLL: begin
        if (sts.copy_done) state_nxt = ST_FILL;
      end
      ST_FILL: begin
        if (sts.fill_done) state_nxt = ST_RESP;
      end
      ST_READ: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (slot_free) state_nxt = accept ? dispatch(in_command) : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    ctl       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_PUT: begin
        ctl.do_put    = 1'b1;
        ctl.ptr_clear = 1'b1;
      end
      ST_SCROLL: begin
        ctl.copy_step = 1'b1;
      end
      ST_FILL: begin
        ctl.fill_step = 1'b1;
      end
      ST_READ: begin
        ctl.read_cell = 1'b1;
      end
      ST_RESP: begin
        ctl.load_out = slot_free;
        in_tready    = slot_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
    if (in_tvalid && in_tready) begin
      ctl.latch_item  = 1'b1;
      ctl.ptr_clear   = 1'b1;
      ctl.home_cursor = (in_command == CMD_CLEAR);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tmcw_dp.sv -----
// ============================================================================
// tmcw_dp: datapath of the text mode console writer
// Holds the screen memory, cursor, color registers, sweep pointer and the
// result register, and carries out the steps the controller commands.
// ============================================================================
`default_nettype none

module tmcw_dp #(
  parameter int COLUMNS   = tmcw_pkg::DEF_COLUMNS,
  parameter int ROWS      = tmcw_pkg::DEF_ROWS,
  parameter int TAB_WIDTH = tmcw_pkg::DEF_TAB_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [tmcw_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic      [tmcw_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [tmcw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tmcw_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire tmcw_pkg::tmcw_ctrl_t              ctl,
  output tmcw_pkg::tmcw_stat_t                   sts
);
  import tmcw_pkg::*;

  localparam int CELL_COUNT    = ROWS * COLUMNS;
  localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;
  localparam int CW            = $clog2(COLUMNS);
  localparam int RW            = $clog2(ROWS);
  localparam int PW            = $clog2(TAB_WIDTH);
  localparam int AW            = $clog2(CELL_COUNT);
  localparam int SW            = $clog2(COLUMNS + TAB_WIDTH);
  localparam int CMPW          = ((AW > ADDR_FW) ? AW : ADDR_FW) + 1;

  logic [DATA_FW-1:0]     screen_mem [CELL_COUNT];

  logic [CMD_FW-1:0]      cmd_r;
  logic [CHAR_FW-1:0]     char_r;
  logic [ADDR_FW-1:0]     addr_r;
  logic [CW-1:0]          col_r;
  logic [RW-1:0]          row_r;
  logic [PW-1:0]          phase_r;
  logic [COLOR_W-1:0]     bg_r;
  logic [COLOR_W-1:0]     fg_r;
  logic [AW-1:0]          ptr_r;
  logic [DATA_FW-1:0]     rd_q_r;
  logic                   rd_sel_r;
  logic [OUT_TDATA_W-1:0] out_r;

  logic [SW-1:0]          ncol;
  logic [PW-1:0]          nphase;
  logic                   row_adv;
  logic                   put_write;
  logic                   last_row;
  logic [AW-1:0]          cur_addr;
  logic [DATA_FW-1:0]     blank_word;
  logic                   addr_ok;

  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [DATA_FW-1:0]     wr_data;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;

  assign cur_addr   = AW'(row_r) * AW'(COLUMNS) + AW'(col_r);
  assign blank_word = {bg_r, fg_r, CH_SPACE};
  assign addr_ok    = CMPW'(addr_r) < CMPW'(CELL_COUNT);
  assign last_row   = (row_r == RW'(ROWS - 1));

  // Cursor movement for a put. The phase register tracks column modulo the
  // tab width, so a tab is one add.
  always_comb begin
    ncol      = SW'(col_r);
    nphase    = phase_r;
    row_adv   = 1'b0;
    put_write = 1'b0;
    if (char_r == CH_BACKSPACE) begin
      if (col_r != '0) begin
        ncol   = SW'(col_r) - SW'(1);
        nphase = (phase_r == '0) ? PW'(TAB_WIDTH - 1) : phase_r - PW'(1);
      end
    end else if (char_r == CH_TAB) begin
      ncol   = SW'(col_r) + SW'(TAB_WIDTH) - SW'(phase_r);
      nphase = '0;
    end else if (char_r == CH_CR) begin
      ncol   = '0;
      nphase = '0;
    end else if (char_r == CH_LINE_FEED) begin
      ncol    = '0;
      nphase  = '0;
      row_adv = 1'b1;
    end else if (!char_r[CHAR_FW-1] && char_r >= CH_SPACE) begin
      put_write = 1'b1;
      ncol      = SW'(col_r) + SW'(1);
      nphase    = (phase_r == PW'(TAB_WIDTH - 1)) ? '0 : phase_r + PW'(1);
    end
    if (ncol >= SW'(COLUMNS)) begin
      ncol    = '0;
      nphase  = '0;
      row_adv = 1'b1;
    end
  end

  assign sts.scroll_req = row_adv && last_row;
  assign sts.copy_done  = (ptr_r == AW'(LAST_ROW_BASE));
  assign sts.fill_done  = (ptr_r == AW'(CELL_COUNT - 1));

  // Memory port selection.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r;
    wr_data = blank_word;
    rd_en   = 1'b0;
    rd_addr = AW'(addr_r);
    if (ctl.do_put) begin
      wr_en   = put_write;
      wr_addr = cur_addr;
      wr_data = {bg_r, fg_r, char_r};
    end else if (ctl.copy_step) begin
      // Read one row ahead and write last cycle's word one row up.
      wr_en   = (ptr_r != '0);
      wr_addr = ptr_r - AW'(1);
      wr_data = rd_q_r;
      rd_en   = (ptr_r != AW'(LAST_ROW_BASE));
      rd_addr = ptr_r + AW'(COLUMNS);
    end else if (ctl.fill_step) begin
      wr_en = 1'b1;
    end else if (ctl.read_cell) begin
      rd_en = addr_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) screen_mem[wr_addr] <= wr_data;
    if (rd_en) rd_q_r <= screen_mem[rd_addr];
  end

  // Item and result registers.
  always_ff @(posedge clk) begin
    if (ctl.latch_item) begin
      cmd_r  <= in_tdata[CMD_LSB +: CMD_FW];
      char_r <= in_tdata[CHAR_LSB +: CHAR_FW];
      addr_r <= in_tdata[ADDR_LSB +: ADDR_FW];
    end
    if (ctl.load_out) begin
      out_r <= {1'b0,
                rd_sel_r ? rd_q_r : DATA_FW'(0),
                LOC_FW'(cur_addr),
                ROW_FW'(row_r),
                COL_FW'(col_r)};
    end
  end

  assign out_tdata = out_r;

  // Cursor, colors, sweep pointer and read select.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      phase_r  <= '0;
      bg_r     <= BG_RESET;
      fg_r     <= FG_RESET;
      ptr_r    <= '0;
      rd_sel_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BACKGROUND: bg_r <= cfg_wdata[COLOR_W-1:0];
          REG_FOREGROUND: fg_r <= cfg_wdata[COLOR_W-1:0];
          default:        bg_r <= bg_r;
        endcase
      end
      if (ctl.home_cursor) begin
        col_r   <= '0;
        row_r   <= '0;
        phase_r <= '0;
      end else if (ctl.do_put) begin
        col_r   <= CW'(ncol);
        phase_r <= nphase;
        if (row_adv && !last_row) row_r <= row_r + RW'(1);
      end
      if (ctl.ptr_clear) begin
        ptr_r <= '0;
      end else if (ctl.fill_step) begin
        ptr_r <= ptr_r + AW'(1);
      end else if (ctl.copy_step && !sts.copy_done) begin
        ptr_r <= ptr_r + AW'(1);
      end else if (ctl.copy_step) begin
        // The fill of the last row starts where the copy stopped.
        ptr_r <= ptr_r;
      end
      if (ctl.latch_item) begin
        rd_sel_r <= 1'b0;
      end else if (ctl.read_cell) begin
        rd_sel_r <= addr_ok && (cmd_r == CMD_READ);
      end
    end
  end

endmodule

`default_nettype wire
